// ----- rtl/core/mcd_pkg.sv -----
package mcd_pkg;

   localparam int CYCLE_UNITS = 1024;
   localparam int W_BITS      = $clog2(CYCLE_UNITS);
   localparam int Q_BITS      = W_BITS - 2;
   localparam int QUARTER     = CYCLE_UNITS / 4;
   localparam int ADDR_BITS   = Q_BITS + 1;

   localparam int ANGLE_BITS  = 32;
   localparam int PEAK_BITS   = 8;
   localparam int DUTY_BITS   = 8;
   localparam int MAG_BITS    = 7;
   localparam int COS_BITS    = 16;
   localparam int PROD_BITS   = MAG_BITS + COS_BITS;

   localparam logic [PEAK_BITS-1:0] DUTY_MAX    = PEAK_BITS'(100);
   localparam logic [PROD_BITS-1:0] ROUND_HALF  = PROD_BITS'(32768);

   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   localparam longint Q30_ONE     = 64'sd1 << 30;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint TAYLOR_DIV_0 = 64'sd182 * Q30_ONE;
   localparam longint TAYLOR_DIV_1 = 64'sd132 * Q30_ONE;
   localparam longint TAYLOR_DIV_2 = 64'sd90 * Q30_ONE;
   localparam longint TAYLOR_DIV_3 = 64'sd56 * Q30_ONE;
   localparam longint TAYLOR_DIV_4 = 64'sd30 * Q30_ONE;
   localparam longint TAYLOR_DIV_5 = 64'sd12 * Q30_ONE;
   localparam longint TAYLOR_DIV_6 = 64'sd2 * Q30_ONE;
   localparam longint Q16_HALF_LSB = 64'sd8192;
   localparam longint Q16_MAX      = 64'sd65535;

   typedef logic [COS_BITS-1:0] cos_table_type [QUARTER+1];

   // quarter-wave cosine in unsigned q0.16 from a truncated taylor series
   function automatic logic [COS_BITS-1:0] cos_entry(input int q);
      longint x;
      longint x2;
      longint t;
      x  = (HALF_PI_Q30 * longint'(q)) / QUARTER;
      x2 = (x * x) / Q30_ONE;
      t  = Q30_ONE;
      t  = Q30_ONE - (x2 * t) / TAYLOR_DIV_0;
      t  = Q30_ONE - (x2 * t) / TAYLOR_DIV_1;
      t  = Q30_ONE - (x2 * t) / TAYLOR_DIV_2;
      t  = Q30_ONE - (x2 * t) / TAYLOR_DIV_3;
      t  = Q30_ONE - (x2 * t) / TAYLOR_DIV_4;
      t  = Q30_ONE - (x2 * t) / TAYLOR_DIV_5;
      t  = Q30_ONE - (x2 * t) / TAYLOR_DIV_6;
      if (t < 0) begin
         t = 0;
      end
      t = (t + Q16_HALF_LSB) >>> 14;
      if (t > Q16_MAX) begin
         t = Q16_MAX;
      end
      return t[COS_BITS-1:0];
   endfunction

   function automatic cos_table_type build_cos_table();
      cos_table_type tbl;
      for (int q = 0; q <= QUARTER; q++) begin
         tbl[q] = cos_entry(q);
      end
      return tbl;
   endfunction

   localparam cos_table_type COS_TABLE = build_cos_table();

endpackage

// ----- rtl/core/microstep_coil_duty_top.sv -----
// Microstep coil duty generator: each transaction carries a signed electrical angle,
// wrapped to one cycle of mcd_pkg::CYCLE_UNITS steps by its low bits, and a peak duty in
// percent clamped to 100; the result gives coil A as rounded cos times peak and coil B as
// rounded minus sine times peak, both in -100..100. A new transaction is taken every
// cycle while req_stall is low; each result passes the registered read of the
// quarter-wave cosine rom (two read ports, at the remainder and its complement) and
// then the multiply, rounding and sign into the output register.
// Back-pressure on the result side fills both stages before req_stall rises.
module microstep_coil_duty_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [mcd_pkg::ANGLE_BITS-1:0]  req_angle,
   input  logic        [mcd_pkg::PEAK_BITS-1:0]   req_peak_duty,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [mcd_pkg::DUTY_BITS-1:0]   rsp_coil_a_duty,
   output logic signed [mcd_pkg::DUTY_BITS-1:0]   rsp_coil_b_duty
);

   logic [mcd_pkg::W_BITS-1:0]    wrap_angle;
   logic [mcd_pkg::Q_BITS-1:0]    rem;
   logic [mcd_pkg::ADDR_BITS-1:0] addr_r;
   logic [mcd_pkg::ADDR_BITS-1:0] addr_c;
   logic [mcd_pkg::MAG_BITS-1:0]  peak_in;

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [1:0]                    quad_ff;
   logic [mcd_pkg::MAG_BITS-1:0]  peak_ff;
   logic [mcd_pkg::COS_BITS-1:0]  cr_ff;
   logic [mcd_pkg::COS_BITS-1:0]  cc_ff;

   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic signed [mcd_pkg::DUTY_BITS-1:0] coil_a_ff;
   logic signed [mcd_pkg::DUTY_BITS-1:0] coil_b_ff;
   logic signed [mcd_pkg::DUTY_BITS-1:0] coil_a_in;
   logic signed [mcd_pkg::DUTY_BITS-1:0] coil_b_in;

   logic                          adv_out;
   logic                          adv_s1;
   logic                          take;

   logic [mcd_pkg::COS_BITS-1:0]  mag_a;
   logic [mcd_pkg::COS_BITS-1:0]  mag_b;
   logic                          neg_a;
   logic                          neg_b;
   logic [mcd_pkg::PROD_BITS-1:0] prod_a;
   logic [mcd_pkg::PROD_BITS-1:0] prod_b;
   logic [mcd_pkg::MAG_BITS-1:0]  m_a;
   logic [mcd_pkg::MAG_BITS-1:0]  m_b;

   assign adv_out   = !out_valid_ff || !rsp_stall;
   assign adv_s1    = !s1_valid_ff || adv_out;
   assign req_stall = !adv_s1;
   assign take      = req_valid && adv_s1;

   // angle wrap and duty clamp
   assign wrap_angle = req_angle[mcd_pkg::W_BITS-1:0];
   assign rem        = wrap_angle[mcd_pkg::Q_BITS-1:0];
   assign addr_r     = {1'b0, rem};
   assign addr_c     = mcd_pkg::ADDR_BITS'(mcd_pkg::QUARTER) - addr_r;
   assign peak_in    = (req_peak_duty > mcd_pkg::DUTY_MAX)
                       ? mcd_pkg::DUTY_MAX[mcd_pkg::MAG_BITS-1:0]
                       : req_peak_duty[mcd_pkg::MAG_BITS-1:0];

   assign s1_valid_in = adv_s1 ? take : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // cosine rom, two synchronous read ports
   always_ff @(posedge clock) begin
      if (take) begin
         cr_ff   <= mcd_pkg::COS_TABLE[addr_r];
         cc_ff   <= mcd_pkg::COS_TABLE[addr_c];
         quad_ff <= wrap_angle[mcd_pkg::W_BITS-1 -: 2];
         peak_ff <= peak_in;
      end
   end

   // quadrant folding
   always_comb begin
      case (quad_ff)
         mcd_pkg::QUAD_FIRST: begin
            mag_a = cr_ff;
            mag_b = cc_ff;
            neg_a = 1'b0;
            neg_b = 1'b1;
         end
         mcd_pkg::QUAD_SECOND: begin
            mag_a = cc_ff;
            mag_b = cr_ff;
            neg_a = 1'b1;
            neg_b = 1'b1;
         end
         mcd_pkg::QUAD_THIRD: begin
            mag_a = cr_ff;
            mag_b = cc_ff;
            neg_a = 1'b1;
            neg_b = 1'b0;
         end
         default: begin
            mag_a = cc_ff;
            mag_b = cr_ff;
            neg_a = 1'b0;
            neg_b = 1'b0;
         end
      endcase
   end

   // scale, round half away from zero, apply sign
   assign prod_a = mcd_pkg::PROD_BITS'(peak_ff) * mcd_pkg::PROD_BITS'(mag_a)
                   + mcd_pkg::ROUND_HALF;
   assign prod_b = mcd_pkg::PROD_BITS'(peak_ff) * mcd_pkg::PROD_BITS'(mag_b)
                   + mcd_pkg::ROUND_HALF;
   assign m_a    = prod_a[mcd_pkg::PROD_BITS-1 -: mcd_pkg::MAG_BITS];
   assign m_b    = prod_b[mcd_pkg::PROD_BITS-1 -: mcd_pkg::MAG_BITS];

   assign coil_a_in = neg_a ? -$signed({1'b0, m_a}) : $signed({1'b0, m_a});
   assign coil_b_in = neg_b ? -$signed({1'b0, m_b}) : $signed({1'b0, m_b});

   assign out_valid_in = adv_out ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out && s1_valid_ff) begin
         coil_a_ff <= coil_a_in;
         coil_b_ff <= coil_b_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_coil_a_duty = coil_a_ff;
   assign rsp_coil_b_duty = coil_b_ff;

   a_stall_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && out_valid_ff))
      else $error("request stalled with a free stage");

   a_result_from_s1 : assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_valid_ff))
      else $error("result without a transaction in the rom stage");

   a_rom_held : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && rsp_stall) |=> ($stable(cr_ff) && $stable(cc_ff)))
      else $error("rom data lost while the result side stalls");

   a_duty_range : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (coil_a_ff >= -8'sd100 && coil_a_ff <= 8'sd100
                        && coil_b_ff >= -8'sd100 && coil_b_ff <= 8'sd100))
      else $error("coil duty out of range");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;

   localparam int     WRAP_MASK   = mcd_pkg::CYCLE_UNITS - 1;
   localparam int     QUARTER_LEN = mcd_pkg::CYCLE_UNITS / 4;
   localparam longint ONE_Q30     = 64'sd1 << 30;
   localparam longint QPI_Q30     = 64'sd1686629713;
   localparam int     PEAK_CLAMP  = 100;

   typedef struct {
      logic signed [31:0] angle;
      logic [7:0]         peak;
      logic signed [7:0]  coil_a;
      logic signed [7:0]  coil_b;
   } coil_duty_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_angle = '0;
   logic [7:0]         req_peak_duty = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [7:0]  rsp_coil_a_duty;
   logic signed [7:0]  rsp_coil_b_duty;

   logic [15:0] cos_q16 [QUARTER_LEN+1];
   coil_duty_t  pending_duties [$];
   int          fail_count = 0;
   bit          gaps_on = 1'b1;
   int          burst_left = 0;
   int          stall_mode = 0;
   int          stall_left = 0;
   int          stall_tick = 0;

   microstep_coil_duty_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_angle       (req_angle),
      .req_peak_duty   (req_peak_duty),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_coil_a_duty (rsp_coil_a_duty),
      .rsp_coil_b_duty (rsp_coil_b_duty)
   );

   always #5 clock = ~clock;

   // eight-term taylor series for cos on one quarter wave
   function automatic logic [15:0] quarter_cos(input int q);
      longint divs [7] = '{182, 132, 90, 56, 30, 12, 2};
      longint x;
      longint xsq;
      longint acc;
      x   = (QPI_Q30 * longint'(q)) / longint'(QUARTER_LEN);
      xsq = (x * x) / ONE_Q30;
      acc = ONE_Q30;
      foreach (divs[i]) begin
         acc = ONE_Q30 - (xsq * acc) / (divs[i] * ONE_Q30);
      end
      if (acc < 0) begin
         acc = 0;
      end
      acc = (acc + 64'sd8192) / 64'sd16384;
      if (acc > 64'sd65535) begin
         acc = 64'sd65535;
      end
      return acc[15:0];
   endfunction

   function automatic logic signed [7:0] scale_duty(input logic [7:0] peak,
                                                    input logic [15:0] mag,
                                                    input bit neg);
      logic [23:0] prod;
      logic [7:0]  m;
      prod = 24'(peak) * 24'(mag) + 24'd32768;
      m    = prod[23:16];
      return neg ? -m : m;
   endfunction

   function automatic coil_duty_t predict_coil_duties(input logic signed [31:0] angle,
                                                      input logic [7:0] peak_in);
      coil_duty_t  d;
      int          w;
      int          rem;
      logic [1:0]  quad;
      logic [7:0]  peak;
      logic [15:0] near;
      logic [15:0] far;
      w    = int'(angle) & WRAP_MASK;
      quad = 2'(w / QUARTER_LEN);
      rem  = w % QUARTER_LEN;
      near = cos_q16[rem];
      far  = cos_q16[QUARTER_LEN - rem];
      peak = (peak_in > PEAK_CLAMP) ? 8'(PEAK_CLAMP) : peak_in;
      d.angle = angle;
      d.peak  = peak_in;
      case (quad)
         mcd_pkg::QUAD_FIRST: begin
            d.coil_a = scale_duty(peak, near, 1'b0);
            d.coil_b = scale_duty(peak, far, 1'b1);
         end
         mcd_pkg::QUAD_SECOND: begin
            d.coil_a = scale_duty(peak, far, 1'b1);
            d.coil_b = scale_duty(peak, near, 1'b1);
         end
         mcd_pkg::QUAD_THIRD: begin
            d.coil_a = scale_duty(peak, near, 1'b1);
            d.coil_b = scale_duty(peak, far, 1'b0);
         end
         default: begin
            d.coil_a = scale_duty(peak, far, 1'b0);
            d.coil_b = scale_duty(peak, near, 1'b0);
         end
      endcase
      return d;
   endfunction

   // optional idle gap before the next transaction, ends on a rising edge
   task automatic sender_gap();
      if (gaps_on) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
   endtask

   task automatic send_angle(input logic signed [31:0] angle, input logic [7:0] peak);
      sender_gap();
      req_valid     <= 1'b1;
      req_angle     <= angle;
      req_peak_duty <= peak;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_duties.push_back(predict_coil_duties(angle, peak));
   endtask

   task automatic test_directed_corners();
      send_angle(0, 100);
      send_angle(256, 100);
      send_angle(512, 100);
      send_angle(768, 100);
      send_angle(1023, 100);
      send_angle(1, 100);
      send_angle(255, 100);
      send_angle(257, 255);
      send_angle(511, 101);
      send_angle(128, 100);
      send_angle(384, 100);
      send_angle(-1, 100);
      send_angle(32'sh8000_0000, 100);
      send_angle(32'sh7fff_ffff, 100);
      send_angle(-256, 200);
      send_angle(640, 0);
      send_angle(0, 255);
      send_angle(256, 1);
      send_angle(250, 1);
      send_angle(768, 1);
      send_angle(100, 50);
      send_angle(1000, 7);
      send_angle(512, 255);
      send_angle(200, 99);
   endtask

   task automatic test_random_items(input int count);
      repeat (count) begin
         send_angle($urandom(), 8'($urandom_range(0, 255)));
      end
   endtask

   // angles close to the quadrant boundaries with in-range peaks
   task automatic test_quadrant_edges(input int count);
      int w;
      repeat (count) begin
         w = $urandom_range(0, 3) * QUARTER_LEN + $urandom_range(0, 8) - 4;
         send_angle(($urandom() & ~WRAP_MASK) | (w & WRAP_MASK),
                    8'($urandom_range(0, PEAK_CLAMP)));
      end
   endtask

   task automatic test_back_to_back(input int count);
      gaps_on = 1'b0;
      repeat (count) begin
         send_angle($urandom(), 8'($urandom_range(0, 255)));
      end
      gaps_on = 1'b1;
   endtask

   // receiver stall pattern, switching between calm, light, heavy and periodic
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
         end
         stall_left--;
         stall_tick++;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 25);
            2: rsp_stall <= ($urandom_range(0, 99) < 70);
            default: rsp_stall <= ((stall_tick % 5) < 2);
         endcase
      end
   end

   always @(posedge clock) begin
      coil_duty_t exp_d;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_duties.size() == 0) begin
            $display("%0t unexpected transaction: expected none, actual a=%0d b=%0d",
                     $time, rsp_coil_a_duty, rsp_coil_b_duty);
            fail_count++;
         end else begin
            exp_d = pending_duties.pop_front();
            if (rsp_coil_a_duty !== exp_d.coil_a) begin
               $display("%0t coil_a (angle %0d peak %0d): expected %0d, actual %0d",
                        $time, exp_d.angle, exp_d.peak, exp_d.coil_a, rsp_coil_a_duty);
               fail_count++;
            end
            if (rsp_coil_b_duty !== exp_d.coil_b) begin
               $display("%0t coil_b (angle %0d peak %0d): expected %0d, actual %0d",
                        $time, exp_d.angle, exp_d.peak, exp_d.coil_b, rsp_coil_b_duty);
               fail_count++;
            end
         end
      end
   end

   initial begin
      for (int q = 0; q <= QUARTER_LEN; q++) begin
         cos_q16[q] = quarter_cos(q);
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_corners();
      test_random_items(900);
      test_quadrant_edges(400);
      test_back_to_back(226);
      req_valid <= 1'b0;
      while (pending_duties.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/mcd_pkg.sv
rtl/core/microstep_coil_duty_top.sv
test/tb.sv
